// ----- rtl/hs_pkg.sv -----
// Shared constants, codes and types of the heap sorter.
`default_nettype none
package hs_pkg;

  localparam int unsigned DEPTH     = 1024;
  localparam int unsigned KEY_WIDTH = 32;
  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_DROP  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_NEXT,
    S_BKEY,
    S_XTOP,
    S_XKEY,
    S_SIFT,
    S_LEFT,
    S_RIGHT,
    S_CMP,
    S_END
  } state_e;

endpackage
`default_nettype wire

// ----- rtl/hs_if.sv -----
// Handshake channels of the heap sorter: input items and result items.
`default_nettype none
interface hs_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic signed [hs_pkg::KEY_WIDTH-1:0] key_in;
  logic                                is_final;

  modport source (output valid, mode, key_in, is_final, input ready);
  modport sink   (input valid, mode, key_in, is_final, output ready);
endinterface

interface hs_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [hs_pkg::KEY_WIDTH-1:0] key_out;
  logic                                final_out;
  logic [1:0]                          status;

  modport source (output valid, key_out, final_out, status, input ready);
  modport sink   (input valid, key_out, final_out, status, output ready);
endinterface
`default_nettype wire

// ----- rtl/hs_key_ram.sv -----
// Simple dual-port key memory: one write and one registered read per cycle.
`default_nettype none
module hs_key_ram #(
  parameter int unsigned AW = 10,
  parameter int unsigned DW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [(1 << AW)];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/heap_sorter.sv -----
// Heap sorter top level: load, in-memory heapsort sequencer and ordered readout.
//
//  channel | dir | payload                      | accepted when
//  in_i    | in  | mode, key_in, is_final       | valid && ready
//  out_o   | out | key_out, final_out, status   | valid && ready
//
// A load writes memory when taken; a read passes the RAM read register and S_RD.
// A load with is_final holds off input for the sort: the build sifts down every
// inner node, then each extraction moves the maximum past the shrinking heap and
// sifts the last key down from the root via S_SIFT, S_LEFT, S_RIGHT and S_CMP.
// A result waits in an output register; a new item is taken once it is free.
// Reset clears count, read pointer and sorted flag; the memory is not cleared.
`default_nettype none
module heap_sorter (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hs_in_if.sink     in_i,
  hs_out_if.source  out_o
);

  localparam int unsigned AW = hs_pkg::ADDR_W;
  localparam int unsigned CW = hs_pkg::CNT_W;
  localparam int unsigned KW = hs_pkg::KEY_WIDTH;

  hs_pkg::state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rp_q, rp_d;
  logic          sorted_q, sorted_d;
  logic          xtract_q, xtract_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] hole_q, hole_d;
  logic [CW-1:0] last_q, last_d;
  logic [CW-1:0] cpos_q, cpos_d;
  logic signed [KW-1:0] key_q, key_d;
  logic signed [KW-1:0] ckey_q, ckey_d;
  logic signed [KW-1:0] top_q, top_d;

  logic                 out_valid_q, out_valid_d;
  logic signed [KW-1:0] out_key_q, out_key_d;
  logic                 out_final_q, out_final_d;
  logic [1:0]           out_status_q, out_status_d;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [KW-1:0] mem_wdata, mem_rdata;
  logic signed [KW-1:0] rdata;

  logic          out_free, in_fire, is_load, rd_ok, sift_more, has_right;
  logic          take_right, key_less;
  logic [CW-1:0] child, load_base, hole_m1;

  hs_key_ram #(.AW(AW), .DW(KW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rdata      = $signed(mem_rdata);
  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == hs_pkg::S_IDLE) && out_free;
  assign in_fire    = in_i.valid && in_i.ready;
  assign is_load    = (in_i.mode == hs_pkg::MODE_LOAD);
  assign rd_ok      = sorted_q && (rp_q < count_q);
  assign load_base  = sorted_q ? '0 : count_q;
  assign child      = {hole_q[CW-2:0], 1'b0};
  assign hole_m1    = hole_q - CW'(1);
  assign sift_more  = hole_q <= (last_q >> 1);
  assign has_right  = child < last_q;
  assign take_right = rdata > ckey_q;
  assign key_less   = key_q < ckey_q;

  assign out_o.valid     = out_valid_q;
  assign out_o.key_out   = out_key_q;
  assign out_o.final_out = out_final_q;
  assign out_o.status    = out_status_q;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hs_pkg::S_IDLE: begin
        if (in_fire) begin
          if (is_load) begin
            if (in_i.is_final) state_d = hs_pkg::S_NEXT;
          end else if (rd_ok) begin
            state_d = hs_pkg::S_RD;
          end
        end
      end
      hs_pkg::S_RD: begin
        if (out_free) state_d = hs_pkg::S_IDLE;
      end
      hs_pkg::S_NEXT: begin
        if (xtract_q) begin
          state_d = (idx_q >= CW'(2)) ? hs_pkg::S_XTOP : hs_pkg::S_IDLE;
        end else if (idx_q != '0) begin
          state_d = hs_pkg::S_BKEY;
        end
      end
      hs_pkg::S_BKEY:  state_d = hs_pkg::S_SIFT;
      hs_pkg::S_XTOP:  state_d = hs_pkg::S_XKEY;
      hs_pkg::S_XKEY:  state_d = hs_pkg::S_SIFT;
      hs_pkg::S_SIFT:  state_d = sift_more ? hs_pkg::S_LEFT : hs_pkg::S_END;
      hs_pkg::S_LEFT:  state_d = has_right ? hs_pkg::S_RIGHT : hs_pkg::S_CMP;
      hs_pkg::S_RIGHT: state_d = hs_pkg::S_CMP;
      hs_pkg::S_CMP:   state_d = key_less ? hs_pkg::S_SIFT : hs_pkg::S_END;
      hs_pkg::S_END:   state_d = hs_pkg::S_NEXT;
      default:         state_d = hs_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory controls and result register.
  always_comb begin
    count_d      = count_q;
    rp_d         = rp_q;
    sorted_d     = sorted_q;
    xtract_d     = xtract_q;
    idx_d        = idx_q;
    hole_d       = hole_q;
    last_d       = last_q;
    cpos_d       = cpos_q;
    key_d        = key_q;
    ckey_d       = ckey_q;
    top_d        = top_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_key_d    = out_key_q;
    out_final_d  = out_final_q;
    out_status_d = out_status_q;
    mem_we       = 1'b0;
    mem_waddr    = hole_m1[AW-1:0];
    mem_wdata    = key_q;
    mem_re       = 1'b0;
    mem_raddr    = '0;

    unique case (state_q)
      hs_pkg::S_IDLE: begin
        if (in_fire) begin
          if (is_load) begin
            out_valid_d  = 1'b1;
            out_key_d    = '0;
            out_final_d  = 1'b0;
            out_status_d = hs_pkg::ST_OK;
            sorted_d     = 1'b0;
            rp_d         = sorted_q ? '0 : rp_q;
            count_d      = load_base;
            if (load_base < CW'(hs_pkg::DEPTH)) begin
              mem_we    = 1'b1;
              mem_waddr = load_base[AW-1:0];
              mem_wdata = in_i.key_in;
              count_d   = load_base + CW'(1);
            end else begin
              out_status_d = hs_pkg::ST_DROP;
            end
            if (in_i.is_final) begin
              idx_d    = count_d >> 1;
              xtract_d = 1'b0;
            end
          end else if (rd_ok) begin
            mem_re    = 1'b1;
            mem_raddr = rp_q[AW-1:0];
          end else begin
            out_valid_d  = 1'b1;
            out_key_d    = '0;
            out_final_d  = 1'b0;
            out_status_d = hs_pkg::ST_EMPTY;
          end
        end
      end
      hs_pkg::S_RD: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_key_d    = rdata;
          out_final_d  = (rp_q + CW'(1)) == count_q;
          out_status_d = hs_pkg::ST_OK;
          rp_d         = rp_q + CW'(1);
        end
      end
      hs_pkg::S_NEXT: begin
        if (xtract_q) begin
          if (idx_q >= CW'(2)) begin
            mem_re    = 1'b1;
            mem_raddr = '0;
          end else begin
            sorted_d = 1'b1;
            rp_d     = '0;
          end
        end else if (idx_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx_q - CW'(1));
        end else begin
          // Heap is built; extraction starts with the whole set.
          xtract_d = 1'b1;
          idx_d    = count_q;
        end
      end
      hs_pkg::S_BKEY: begin
        key_d  = rdata;
        hole_d = idx_q;
        last_d = count_q;
      end
      hs_pkg::S_XTOP: begin
        top_d     = rdata;
        mem_re    = 1'b1;
        mem_raddr = AW'(idx_q - CW'(1));
      end
      hs_pkg::S_XKEY: begin
        key_d  = rdata;
        hole_d = CW'(1);
        last_d = idx_q - CW'(1);
      end
      hs_pkg::S_SIFT: begin
        if (sift_more) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(child - CW'(1));
        end else begin
          mem_we = 1'b1;
        end
      end
      hs_pkg::S_LEFT: begin
        ckey_d = rdata;
        cpos_d = child;
        if (has_right) begin
          mem_re    = 1'b1;
          mem_raddr = child[AW-1:0];
        end
      end
      hs_pkg::S_RIGHT: begin
        if (take_right) begin
          ckey_d = rdata;
          cpos_d = cpos_q + CW'(1);
        end
      end
      hs_pkg::S_CMP: begin
        mem_we = 1'b1;
        if (key_less) begin
          mem_wdata = ckey_q;
          hole_d    = cpos_q;
        end
      end
      hs_pkg::S_END: begin
        // In extraction the old maximum goes just past the shrunken heap.
        if (xtract_q) begin
          mem_we    = 1'b1;
          mem_waddr = last_q[AW-1:0];
          mem_wdata = top_q;
        end
        idx_d = idx_q - CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hs_pkg::S_IDLE;
      count_q     <= '0;
      rp_q        <= '0;
      sorted_q    <= 1'b0;
      xtract_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rp_q        <= rp_d;
      sorted_q    <= sorted_d;
      xtract_q    <= xtract_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    hole_q       <= hole_d;
    last_q       <= last_d;
    cpos_q       <= cpos_d;
    key_q        <= key_d;
    ckey_q       <= ckey_d;
    top_q        <= top_d;
    out_key_q    <= out_key_d;
    out_final_q  <= out_final_d;
    out_status_q <= out_status_d;
  end

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("key memory read and write hit the same entry");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(hs_pkg::DEPTH))
    else $error("element count exceeds the store depth");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hs_pkg::S_RD |-> sorted_q && (rp_q < count_q))
    else $error("readout of an entry outside the sorted set");

  a_hole_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hs_pkg::S_SIFT |-> (hole_q != '0) && (hole_q <= last_q)
                                  && (last_q <= count_q))
    else $error("sift-down hole outside the heap");

  a_sort_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hs_pkg::S_NEXT && state_d == hs_pkg::S_IDLE |=> sorted_q && rp_q == '0)
    else $error("sort finished without marking the set sorted");

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench of the heap sorter: loads key sets, reads them back sorted.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [hs_pkg::KEY_WIDTH-1:0] key_t;

  typedef struct {
    key_t       key;
    logic       fin;
    logic [1:0] status;
  } result_t;

  localparam key_t KEY_MAX = {1'b0, {(hs_pkg::KEY_WIDTH-1){1'b1}}};
  localparam key_t KEY_MIN = {1'b1, {(hs_pkg::KEY_WIDTH-1){1'b0}}};

  logic clk_i = 1'b0;
  logic rst_ni;

  hs_in_if  in_ch ();
  hs_out_if out_ch ();

  heap_sorter u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the block's key store and read state.
  key_t        shadow_keys [hs_pkg::DEPTH];
  int unsigned shadow_count;
  int unsigned shadow_rd_ptr;
  logic        shadow_sorted;

  result_t     awaited_results [$];
  int unsigned errors = 0;
  logic        idle_off;
  int unsigned sink_hold;

  // Any correct sort of the same keys gives the same ascending sequence.
  function automatic void sort_shadow_keys();
    key_t        held;
    int unsigned j;
    for (int unsigned i = 1; i < shadow_count; i++) begin
      held = shadow_keys[i];
      j = i;
      while (j > 0 && shadow_keys[j-1] > held) begin
        shadow_keys[j] = shadow_keys[j-1];
        j--;
      end
      shadow_keys[j] = held;
    end
  endfunction

  function automatic result_t predict_result(logic m, key_t k, logic f);
    result_t r;
    r.key    = '0;
    r.fin    = 1'b0;
    r.status = hs_pkg::ST_OK;
    if (m == hs_pkg::MODE_LOAD) begin
      if (shadow_sorted) begin
        shadow_count  = 0;
        shadow_rd_ptr = 0;
        shadow_sorted = 1'b0;
      end
      if (shadow_count < hs_pkg::DEPTH) begin
        shadow_keys[shadow_count] = k;
        shadow_count++;
      end else begin
        r.status = hs_pkg::ST_DROP;
      end
      if (f) begin
        sort_shadow_keys();
        shadow_rd_ptr = 0;
        shadow_sorted = 1'b1;
      end
    end else if (!shadow_sorted || shadow_rd_ptr >= shadow_count) begin
      r.status = hs_pkg::ST_EMPTY;
    end else begin
      r.key = shadow_keys[shadow_rd_ptr];
      r.fin = (shadow_rd_ptr + 1 == shadow_count);
      shadow_rd_ptr++;
    end
    return r;
  endfunction

  function automatic int unsigned draw_gap();
    int unsigned pick;
    if (idle_off) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Flavor 0: any value, 1: a narrow band full of duplicates, else: mostly corner values.
  function automatic key_t draw_key(int unsigned flavor);
    case (flavor)
      0: return key_t'($urandom);
      1: return key_t'(int'($urandom_range(0, 8)) - 4);
      default: begin
        case ($urandom_range(0, 7))
          0: return KEY_MIN;
          1: return KEY_MAX;
          2: return KEY_MIN + 1;
          3: return KEY_MAX - 1;
          4: return '0;
          5: return '1;
          6: return key_t'(1);
          default: return key_t'($urandom);
        endcase
      end
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(logic m, key_t k, logic f);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= m;
    in_ch.key_in   <= k;
    in_ch.is_final <= f;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    awaited_results.push_back(predict_result(m, k, f));
    @(negedge clk_i);
  endtask

  task automatic send_read();
    send_item(hs_pkg::MODE_READ, draw_key(0), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_read_before_sort();
    send_item(hs_pkg::MODE_READ, KEY_MAX, 1'b1);
    send_item(hs_pkg::MODE_READ, '0, 1'b0);
  endtask

  task automatic test_single_key();
    send_item(hs_pkg::MODE_LOAD, KEY_MIN, 1'b1);
    send_item(hs_pkg::MODE_READ, '0, 1'b0);
    send_item(hs_pkg::MODE_READ, '1, 1'b1);
  endtask

  task automatic test_extremes_and_reload();
    send_item(hs_pkg::MODE_LOAD, KEY_MAX, 1'b0);
    send_item(hs_pkg::MODE_LOAD, KEY_MIN, 1'b0);
    send_item(hs_pkg::MODE_LOAD, '0, 1'b0);
    send_read();
    send_item(hs_pkg::MODE_LOAD, '1, 1'b0);
    send_item(hs_pkg::MODE_LOAD, key_t'(1), 1'b0);
    send_item(hs_pkg::MODE_LOAD, KEY_MAX, 1'b0);
    send_item(hs_pkg::MODE_LOAD, KEY_MIN + 1, 1'b1);
    repeat (3) send_read();
    // A load into a partly read sorted set starts a fresh set.
    send_item(hs_pkg::MODE_LOAD, key_t'(5), 1'b0);
    send_item(hs_pkg::MODE_LOAD, key_t'(-5), 1'b1);
    repeat (3) send_read();
  endtask

  task automatic test_store_full();
    for (int unsigned i = 0; i < hs_pkg::DEPTH + 2; i++)
      send_item(hs_pkg::MODE_LOAD, draw_key(0), i == hs_pkg::DEPTH + 1);
    // The smallest kept keys show that the full set was sorted.
    repeat (8) send_read();
  endtask

  task automatic test_random_sets(int unsigned target);
    int unsigned sent;
    int unsigned n;
    int unsigned flavor;
    int unsigned style;
    int unsigned reads;
    sent = 0;
    while (sent < target) begin
      idle_off = ($urandom_range(0, 7) == 0);
      style    = $urandom_range(0, 9);
      flavor   = $urandom_range(0, 3);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: n = $urandom_range(1, 8);
        6, 7, 8:          n = $urandom_range(9, 40);
        default:          n = $urandom_range(41, 120);
      endcase
      for (int unsigned k = 0; k < n; k++) begin
        if (style == 0 && $urandom_range(0, 4) == 0) begin
          send_read();
          sent++;
        end
        send_item(hs_pkg::MODE_LOAD, draw_key(flavor), k == n - 1);
      end
      // Style 1 abandons the set part way through its readout.
      reads = (style == 1) ? $urandom_range(0, n - 1) : n + $urandom_range(0, 2);
      repeat (reads) send_read();
      sent += n + reads;
    end
    idle_off = 1'b0;
  endtask

  always @(negedge clk_i) begin
    int unsigned pick;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      sink_hold = 0;
    end else if (sink_hold == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        out_ch.ready <= 1'b1;
        sink_hold = $urandom_range(1, 12);
      end else if (pick < 65) begin
        out_ch.ready <= 1'b1;
        sink_hold = $urandom_range(40, 200);
      end else if (pick < 95) begin
        out_ch.ready <= 1'b0;
        sink_hold = $urandom_range(1, 3);
      end else begin
        out_ch.ready <= 1'b0;
        sink_hold = $urandom_range(10, 50);
      end
    end else begin
      sink_hold--;
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result transaction: key_out %0d, status %0d",
               out_ch.key_out, out_ch.status);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (out_ch.key_out !== want.key) begin
          $error("key_out: expected %0d, got %0d", want.key, out_ch.key_out);
          errors++;
        end
        if (out_ch.final_out !== want.fin) begin
          $error("final_out: expected %0d, got %0d", want.fin, out_ch.final_out);
          errors++;
        end
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = hs_pkg::MODE_LOAD;
    in_ch.key_in    = '0;
    in_ch.is_final  = 1'b0;
    idle_off        = 1'b0;
    shadow_count    = 0;
    shadow_rd_ptr   = 0;
    shadow_sorted   = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_read_before_sort();
    test_single_key();
    test_extremes_and_reload();
    test_store_full();
    test_random_sets(200);

    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
